/* src/rwlq_pkg.sv */
// Shared types, constants and command codes of the lock request queue.
package rwlq_pkg;

  // Queue geometry
  localparam int QueueDepth = 16;
  localparam int IDX_W      = $clog2(QueueDepth);
  localparam int CNT_W      = $clog2(QueueDepth + 1);
  localparam int OCC_W      = 5;
  localparam int THREAD_W   = 16;
  localparam int RECORD_W   = 32;

  typedef logic [QueueDepth-1:0] qvec_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Request codes as they arrive on the input channel
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_LOCK   = 2'd1,
    MODE_UNLOCK = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  // Classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_LOCK_SH,
    OP_LOCK_EX,
    OP_UNLOCK_SH,
    OP_UNLOCK_EX,
    OP_REMOVE
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_st_t;

  // Input beat
  typedef struct packed {
    mode_t               mode;
    logic [THREAD_W-1:0] thread_id;
    logic [RECORD_W-1:0] record_id;
    logic                shared;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic             found;
    logic             overflow;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // Command after classification
  typedef struct packed {
    op_t                 op;
    logic [THREAD_W-1:0] thread_id;
    logic [RECORD_W-1:0] record_id;
    logic                shared;
  } cmd_t;

  // One queue slot
  typedef struct packed {
    logic [THREAD_W-1:0] thread_id;
    logic [RECORD_W-1:0] record_id;
    logic                is_shared;
    logic                granted;
  } entry_t;

  // Handshake between the command queue and the back end
  typedef struct packed {
    logic avail;
    cmd_t head;
  } cmd_port_t;

  // Handshake between the back end and the result buffer
  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_port_t;

endpackage

/* src/rwlq_front.sv */
// Front end: accepts request beats, classifies them and queues up to two commands.
module rwlq_front import rwlq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output cmd_port_t cmd_port,
  input  logic      cmd_pop
);

  cmd_t       slot_r [2];
  cmd_t       cmd_in;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  // Classify the request mode and lock kind into one operation
  always_comb begin
    cmd_in.thread_id = in_item.thread_id;
    cmd_in.record_id = in_item.record_id;
    cmd_in.shared    = in_item.shared;
    unique case (in_item.mode)
      MODE_APPEND: cmd_in.op = OP_APPEND;
      MODE_LOCK:   cmd_in.op = in_item.shared ? OP_LOCK_SH : OP_LOCK_EX;
      MODE_UNLOCK: cmd_in.op = in_item.shared ? OP_UNLOCK_SH : OP_UNLOCK_EX;
      MODE_REMOVE: cmd_in.op = OP_REMOVE;
      default:     cmd_in.op = OP_REMOVE;
    endcase
  end

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = cmd_pop && (cnt_r != 2'd0);

  assign cmd_port.avail = (cnt_r != 2'd0);
  assign cmd_port.head  = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Command slots, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* src/rwlq_back.sv */
// Back end: holds the ordered entries, matches a command and applies it.
module rwlq_back import rwlq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_port_t cmd_port,
  output logic      cmd_pop,
  input  logic      res_space,
  output res_port_t res_port
);

  entry_t   entry_r [QueueDepth];
  entry_t   entry_nxt [QueueDepth];
  cnt_t     count_r, count_nxt;
  back_st_t st_r, st_nxt;
  cmd_t     cmd_r, cmd_nxt;
  qvec_t    hit_r, hit_nxt;

  qvec_t valid, idm, shr, exbits, firstex, run;
  qvec_t first, after;
  logic  start;
  logic  has_room;

  // Per-slot compare of the queue head command against the entries
  always_comb begin
    for (int k = 0; k < QueueDepth; k++) begin
      valid[k] = (CNT_W'(k) < count_r);
      idm[k]   = (entry_r[k].thread_id == cmd_port.head.thread_id) &&
                 (entry_r[k].record_id == cmd_port.head.record_id);
      shr[k]   = entry_r[k].is_shared;
    end
    // Leading shared run: every valid slot below the first exclusive one
    exbits  = valid & ~shr;
    firstex = exbits & (~exbits + 1'b1);
    run     = (firstex - 1'b1) & valid;
  end

  // Candidate slots per operation
  always_comb begin
    hit_nxt = '0;
    unique case (cmd_port.head.op)
      OP_APPEND:    hit_nxt = '0;
      OP_LOCK_SH:   hit_nxt = run & idm;
      OP_LOCK_EX:   hit_nxt[0] = valid[0] & idm[0] & ~shr[0];
      OP_UNLOCK_SH: hit_nxt = run & idm;
      OP_UNLOCK_EX: hit_nxt[0] = valid[0] & entry_r[0].granted & ~shr[0];
      OP_REMOVE:    hit_nxt = valid & idm & ~(shr ^ {QueueDepth{cmd_port.head.shared}});
      default:      hit_nxt = '0;
    endcase
  end

  // First candidate and the slots at or above it
  assign first    = hit_r & (~hit_r + 1'b1);
  assign after    = ~(first - 1'b1);
  assign has_room = (count_r < CNT_W'(QueueDepth));
  assign start    = cmd_port.avail && res_space;

  // Sequencer: latch and match, then apply and report
  always_comb begin
    st_nxt    = st_r;
    cmd_nxt   = cmd_r;
    count_nxt = count_r;
    cmd_pop   = 1'b0;
    res_port  = '0;
    for (int k = 0; k < QueueDepth; k++) begin
      entry_nxt[k] = entry_r[k];
    end
    unique case (st_r)
      BK_IDLE: begin
        if (start) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_port.head;
          st_nxt  = BK_EXEC;
        end
      end
      BK_EXEC: begin
        st_nxt        = BK_IDLE;
        res_port.push = 1'b1;
        case (cmd_r.op)
          OP_APPEND: begin
            if (has_room) begin
              entry_nxt[count_r[IDX_W-1:0]].thread_id = cmd_r.thread_id;
              entry_nxt[count_r[IDX_W-1:0]].record_id = cmd_r.record_id;
              entry_nxt[count_r[IDX_W-1:0]].is_shared = cmd_r.shared;
              entry_nxt[count_r[IDX_W-1:0]].granted   = 1'b0;
              count_nxt               = count_r + 1'b1;
              res_port.item.found     = 1'b1;
            end else begin
              res_port.item.overflow  = 1'b1;
            end
          end
          OP_LOCK_SH, OP_LOCK_EX: begin
            res_port.item.found = |hit_r;
            for (int k = 0; k < QueueDepth; k++) begin
              entry_nxt[k].granted = entry_r[k].granted | first[k];
            end
          end
          default: begin
            // Removal: slots from the hit upward take their upper neighbor
            res_port.item.found = |hit_r;
            if (|hit_r) begin
              for (int k = 0; k < QueueDepth - 1; k++) begin
                if (after[k]) begin
                  entry_nxt[k] = entry_r[k+1];
                end
              end
              count_nxt = count_r - 1'b1;
            end
          end
        endcase
        res_port.item.occupancy = OCC_W'(count_nxt);
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    hit_r <= hit_nxt;
    for (int k = 0; k < QueueDepth; k++) begin
      entry_r[k] <= entry_nxt[k];
    end
  end

endmodule

/* src/rwlq_res_buf.sv */
// Result buffer: two-slot queue between the back end and the result channel.
module rwlq_res_buf import rwlq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_port_t res_port,
  output logic      res_space,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  out_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign empty     = (cnt_r == 2'd0);
  assign res_space = (cnt_r != 2'd2);
  assign do_push   = res_port.push && res_space;
  assign do_pop    = pop && !empty;
  assign out_item  = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result slots, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= res_port.item;
    end
  end

endmodule

/* src/rw_lock_request_queue.sv */
// Top level of the lock request queue for one resource.
//
// Input channel: a request beat (mode, thread_id, record_id, shared) is taken
// on a rising edge with push high and full low. The front end classifies it
// and holds up to two commands. Result channel: while empty is low the oldest
// result (found, overflow, occupancy) is on out_item; it is taken on a rising
// edge with pop high.
// Each request gives exactly one result beat, in request order.
// The back end takes one request at a time: it latches the command and the
// match of all slots, then grants, compacts or appends in the next state, and
// starts a new one only while the result buffer has space. A request passes
// the command queue, the latch and apply states and the result buffer in turn.
// Reset (rst_n low, synchronous) empties the queue and both buffers.
// If the receiver stalls, two results wait in the result buffer, two more
// requests wait in the command queue, then full rises until pop resumes.
module rw_lock_request_queue import rwlq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  cmd_port_t cmd_port;
  logic      cmd_pop;
  res_port_t res_port;
  logic      res_space;

  // Accept and classify
  rwlq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_port (cmd_port),
    .cmd_pop  (cmd_pop)
  );

  // Match and update the entries
  rwlq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_port  (cmd_port),
    .cmd_pop   (cmd_pop),
    .res_space (res_space),
    .res_port  (res_port)
  );

  // Hold results for the receiver
  rwlq_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_port  (res_port),
    .res_space (res_space),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule
